// File: hdl/chrs_pkg.sv
// chrs_pkg: command and status codes, tombstone key and record layout
// constants for the chained hash record store. no dependencies.
`default_nettype none
package chrs_pkg;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_LOOKUP = 3'd1,
    CMD_READ   = 3'd2,
    CMD_WRITE  = 3'd3,
    CMD_REMOVE = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_SLOT     = 3'd4,
    ST_BROKEN   = 3'd5
  } status_e;

  localparam logic [63:0] TOMB_KEY = 64'h7FFF_FFFF_FFFF_FFFF;
  // record header: next link, key, value count
  localparam int unsigned HDR = 3;
  localparam int unsigned IDX_W = 12;

endpackage
`default_nettype wire

// File: hdl/chrs_if.sv
// chrs_cmd_if / chrs_rsp_if: valid/ready channels for command beats and
// result beats. uses no package.
`default_nettype none
interface chrs_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic signed [63:0] key;
  logic [4:0]  value_count;
  logic [3:0]  value_slot;
  logic signed [63:0] write_data;
  modport source (output valid, command, key, value_count, value_slot, write_data,
                  input ready);
  modport sink (input valid, command, key, value_count, value_slot, write_data,
                output ready);
endinterface

interface chrs_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [11:0] record_index;
  logic signed [63:0] read_data;
  modport source (output valid, status, record_index, read_data, input ready);
  modport sink (input valid, status, record_index, read_data, output ready);
endinterface
`default_nettype wire

// File: hdl/chained_hash_record_store_core.sv
// chained_hash_record_store_core: top level, command sequencer around the
// table ram. depends on chrs_pkg, chrs_if, chrs_ram, chrs_bucket.
`default_nettype none
// Hash table with separate chaining in one word ram (one read, one write per
// cycle, registered read data). One command is worked at a time and gives
// one result beat. After reset the block clears the bucket heads, one per
// cycle, min(BUCKETS, WORDS) words in all, before it takes its first command.
// A command first selects its bucket (a mask when BUCKETS is a power of two,
// a serial remainder otherwise), then reads link, key and count of each record
// walked in its bucket chain, then gives its result, after a value read for a
// read or the chain end state when the chain runs out. Commands rejected up
// front go straight to the result. An add that creates a record makes
// 4 + value_count writes, a reuse 1 + value_count. A finished result sits in an
// output register while the next command is taken.
module chained_hash_record_store_core #(
  parameter int unsigned BUCKETS    = 256,
  parameter int unsigned WORDS      = 4096,
  parameter int unsigned MAX_VALUES = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  chrs_cmd_if.sink    cmd_i,
  chrs_rsp_if.source  rsp_o
);
  import chrs_pkg::*;

  localparam int unsigned AW    = $clog2(WORDS);
  localparam int unsigned BW    = $clog2(BUCKETS);
  localparam int unsigned NW    = AW + 1;
  localparam int unsigned SW    = AW + 2;
  localparam int unsigned RW    = (AW > IDX_W) ? AW : IDX_W;
  localparam int unsigned CLR_N = (BUCKETS < WORDS) ? BUCKETS : WORDS;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_CLR  = 11'b000_0000_0010,
    S_BKT  = 11'b000_0000_0100,
    S_LINK = 11'b000_0000_1000,
    S_KEY  = 11'b000_0001_0000,
    S_CNT  = 11'b000_0010_0000,
    S_RDV  = 11'b000_0100_0000,
    S_END  = 11'b000_1000_0000,
    S_APP  = 11'b001_0000_0000,
    S_ZERO = 11'b010_0000_0000,
    S_RESP = 11'b100_0000_0000
  } state_e;

  state_e        state_q, state_d;
  logic [AW:0]   clr_q, clr_d;
  logic [NW-1:0] nf_q, nf_d;
  logic          ovld_q, ovld_d;
  status_e       ost_q, ost_d;
  logic [11:0]   orec_q, orec_d;
  logic [63:0]   odata_q, odata_d;

  cmd_e          cmd_q;
  logic [63:0]   key_q, wdat_q, kw_q;
  logic [4:0]    count_q;
  logic [3:0]    slot_q;
  logic [AW-1:0] prev_q, prev_d, rec_q, rec_d, reuse_q, reuse_d;
  logic          have_q, have_d;
  logic [4:0]    zidx_q, zidx_d;
  logic [1:0]    step_q, step_d;
  status_e       pst_q, pst_d;
  logic [63:0]   pdata_q, pdata_d;
  logic [AW-1:0] prec_q, prec_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;

  logic          bkt_start, bkt_done;
  logic [BW-1:0] bkt;
  logic          accept, is_add;
  logic [SW-1:0] slot_end, reuse_end, nf_end;
  logic [RW-1:0] rec_ext;

  chrs_ram #(.WIDTH(64), .DEPTH(WORDS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  chrs_bucket #(.BUCKETS(BUCKETS)) u_bucket (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (bkt_start),
    .key_i    (key_q),
    .done_o   (bkt_done),
    .bucket_o (bkt)
  );

  assign cmd_i.ready        = (state_q == S_IDLE);
  assign accept             = cmd_i.valid && cmd_i.ready;
  assign is_add             = (cmd_q == CMD_ADD);
  assign rsp_o.valid        = ovld_q;
  assign rsp_o.status       = ost_q;
  assign rsp_o.record_index = orec_q;
  assign rsp_o.read_data    = odata_q;

  assign slot_end  = SW'(rec_q) + SW'(HDR) + SW'(slot_q);
  assign reuse_end = SW'(reuse_q) + SW'(HDR) + SW'(count_q);
  assign nf_end    = SW'(nf_q) + SW'(HDR) + SW'(count_q);
  assign rec_ext   = RW'(prec_q);

  // latch the command beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_e'(cmd_i.command);
      key_q   <= cmd_i.key;
      count_q <= cmd_i.value_count;
      slot_q  <= cmd_i.value_slot;
      wdat_q  <= cmd_i.write_data;
    end
    if (state_q == S_KEY) begin
      kw_q <= ram_rdata;
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    nf_d      = nf_q;
    prev_d    = prev_q;
    rec_d     = rec_q;
    reuse_d   = reuse_q;
    have_d    = have_q;
    zidx_d    = zidx_q;
    step_d    = step_q;
    pst_d     = pst_q;
    pdata_d   = pdata_q;
    prec_d    = prec_q;
    ovld_d    = ovld_q && !rsp_o.ready;
    ost_d     = ost_q;
    orec_d    = orec_q;
    odata_d   = odata_q;
    ram_we    = 1'b0;
    ram_waddr = rec_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = rec_q;
    bkt_start = 1'b0;

    unique case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q[AW-1:0];
        clr_d     = clr_q + (AW+1)'(1);
        if (clr_q == (AW+1)'(CLR_N - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          have_d  = 1'b0;
          pdata_d = '0;
          prec_d  = '0;
          state_d = S_RESP;
          if (cmd_i.command > CMD_REMOVE) begin
            pst_d = ST_NOTFOUND;
          end else if (cmd_i.command == CMD_ADD) begin
            if (32'(cmd_i.value_count) > MAX_VALUES) begin
              pst_d = ST_SLOT;
            end else if (cmd_i.key == TOMB_KEY) begin
              pst_d = ST_DUP;
            end else begin
              bkt_start = 1'b0;
              state_d   = S_BKT;
            end
          end else if (cmd_i.key == TOMB_KEY) begin
            pst_d = ST_NOTFOUND;
          end else begin
            state_d = S_BKT;
          end
        end
      end
      S_BKT: begin
        // bucket unit is started the cycle after the beat is latched
        bkt_start = (step_q == 2'd0);
        step_d    = 2'd1;
        if (bkt_done) begin
          step_d = 2'd0;
          if (32'(bkt) >= WORDS) begin
            pst_d   = ST_BROKEN;
            state_d = S_RESP;
          end else begin
            prev_d    = AW'(bkt);
            ram_re    = 1'b1;
            ram_raddr = AW'(bkt);
            state_d   = S_LINK;
          end
        end
      end
      S_LINK: begin
        if (ram_rdata == '0) begin
          state_d = S_END;
        end else if (!(ram_rdata > 64'(prev_q) && ram_rdata <= 64'(WORDS - HDR))) begin
          pst_d   = ST_BROKEN;
          state_d = S_RESP;
        end else begin
          rec_d     = ram_rdata[AW-1:0];
          ram_re    = 1'b1;
          ram_raddr = ram_rdata[AW-1:0] + AW'(1);
          state_d   = S_KEY;
        end
      end
      S_KEY: begin
        ram_re    = 1'b1;
        ram_raddr = rec_q + AW'(2);
        state_d   = S_CNT;
      end
      S_CNT: begin
        // ram_rdata holds the record's value count
        ram_re    = 1'b1;
        ram_raddr = rec_q;
        prev_d    = rec_q;
        state_d   = S_LINK;
        if (is_add) begin
          if (!have_q && kw_q == TOMB_KEY && ram_rdata == 64'(count_q)) begin
            have_d  = 1'b1;
            reuse_d = rec_q;
          end else if (kw_q == key_q) begin
            ram_re  = 1'b0;
            pst_d   = ST_DUP;
            state_d = S_RESP;
          end
        end else if (kw_q == key_q) begin
          ram_re  = 1'b0;
          state_d = S_RESP;
          pst_d   = ST_OK;
          prec_d  = rec_q;
          priority case (cmd_q)
            CMD_READ, CMD_WRITE: begin
              if (64'(slot_q) >= ram_rdata || slot_end >= SW'(WORDS)) begin
                pst_d = ST_SLOT;
              end else if (cmd_q == CMD_READ) begin
                ram_re    = 1'b1;
                ram_raddr = slot_end[AW-1:0];
                state_d   = S_RDV;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = slot_end[AW-1:0];
                ram_wdata = wdat_q;
              end
            end
            CMD_REMOVE: begin
              ram_we    = 1'b1;
              ram_waddr = rec_q + AW'(1);
              ram_wdata = TOMB_KEY;
            end
            default: ;
          endcase
        end
      end
      S_RDV: begin
        pdata_d = ram_rdata;
        state_d = S_RESP;
      end
      S_END: begin
        state_d = S_RESP;
        if (!is_add) begin
          pst_d = ST_NOTFOUND;
        end else if (have_q) begin
          if (reuse_end > SW'(WORDS)) begin
            pst_d = ST_BROKEN;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = reuse_q + AW'(1);
            ram_wdata = key_q;
            rec_d     = reuse_q;
            zidx_d    = '0;
            state_d   = S_ZERO;
          end
        end else if (nf_end > SW'(WORDS)) begin
          pst_d = ST_FULL;
        end else begin
          rec_d   = nf_q[AW-1:0];
          step_d  = 2'd0;
          state_d = S_APP;
        end
      end
      S_APP: begin
        ram_we = 1'b1;
        step_d = step_q + 2'd1;
        unique case (step_q)
          2'd0: begin
            ram_waddr = prev_q;
            ram_wdata = 64'(rec_q);
          end
          2'd1: ram_wdata = '0;
          2'd2: begin
            ram_waddr = rec_q + AW'(1);
            ram_wdata = key_q;
          end
          default: begin
            ram_waddr = rec_q + AW'(2);
            ram_wdata = 64'(count_q);
            nf_d      = nf_end[NW-1:0];
            zidx_d    = '0;
            state_d   = S_ZERO;
          end
        endcase
      end
      S_ZERO: begin
        if (zidx_q == count_q) begin
          pst_d   = ST_OK;
          prec_d  = rec_q;
          state_d = S_RESP;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = rec_q + AW'(HDR) + AW'(zidx_q);
          zidx_d    = zidx_q + 5'd1;
        end
      end
      S_RESP: begin
        if (!ovld_q || rsp_o.ready) begin
          ovld_d  = 1'b1;
          ost_d   = pst_q;
          orec_d  = (pst_q == ST_OK) ? rec_ext[IDX_W-1:0] : '0;
          odata_d = (pst_q == ST_OK) ? pdata_q : '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      nf_q    <= NW'(BUCKETS);
      ovld_q  <= 1'b0;
      step_q  <= '0;
      have_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      nf_q    <= nf_d;
      ovld_q  <= ovld_d;
      step_q  <= step_d;
      have_q  <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q  <= prev_d;
    rec_q   <= rec_d;
    reuse_q <= reuse_d;
    zidx_q  <= zidx_d;
    pst_q   <= pst_d;
    pdata_q <= pdata_d;
    prec_q  <= prec_d;
    ost_q   <= ost_d;
    orec_q  <= orec_d;
    odata_q <= odata_d;
  end
endmodule
`default_nettype wire

// File: hdl/chrs_ram.sv
// chrs_ram: generic single-write, single-read ram with registered read data.
// no dependencies.
`default_nettype none
module chrs_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule
`default_nettype wire

// File: hdl/chrs_bucket.sv
// chrs_bucket: key modulo bucket count. a mask for a power-of-two count,
// otherwise a radix-16 compare-and-subtract remainder over the key's nibbles. no dependencies.
`default_nettype none
module chrs_bucket #(
  parameter int unsigned BUCKETS = 256
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [63:0]                key_i,
  output logic                            done_o,
  output logic [$clog2(BUCKETS)-1:0]      bucket_o
);
  localparam int unsigned BW = $clog2(BUCKETS);

  if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_mask
    logic          done_q;
    logic [BW-1:0] bkt_q;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end
    always_ff @(posedge clk_i) begin
      if (start_i) begin
        bkt_q <= key_i[BW-1:0];
      end
    end
    assign done_o   = done_q;
    assign bucket_o = bkt_q;
  end else begin : g_serial
    localparam int unsigned TW = BW + 4;
    localparam logic [TW-1:0] D1 = TW'(BUCKETS);
    localparam logic [TW-1:0] D2 = TW'(BUCKETS * 2);
    localparam logic [TW-1:0] D4 = TW'(BUCKETS * 4);
    localparam logic [TW-1:0] D8 = TW'(BUCKETS * 8);
    logic          busy_q, done_q;
    logic [3:0]    cnt_q;
    logic [63:0]   sh_q;
    logic [BW-1:0] rem_q;
    logic [TW-1:0] t0, t1, t2, t3, t4;

    // one nibble per cycle: rem*16 + nibble stays below 16 buckets
    assign t0 = {rem_q, sh_q[63:60]};
    assign t1 = (t0 >= D8) ? t0 - D8 : t0;
    assign t2 = (t1 >= D4) ? t1 - D4 : t1;
    assign t3 = (t2 >= D2) ? t2 - D2 : t2;
    assign t4 = (t3 >= D1) ? t3 - D1 : t3;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        done_q <= 1'b0;
        cnt_q  <= '0;
      end else begin
        done_q <= 1'b0;
        if (start_i) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end else if (busy_q) begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (start_i) begin
        sh_q  <= key_i;
        rem_q <= '0;
      end else if (busy_q) begin
        sh_q  <= {sh_q[59:0], 4'b0};
        rem_q <= t4[BW-1:0];
      end
    end
    assign done_o   = done_q;
    assign bucket_o = rem_q;
  end
endmodule
`default_nettype wire

// File: hdl/chrs_checker.sv
// chrs_checker: port-level checks on the record store and the bind that
// attaches them to the top level. depends on chrs_pkg.
`default_nettype none
module chrs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cmd_valid_i,
  input wire logic        cmd_ready_i,
  input wire logic        rsp_valid_i,
  input wire logic        rsp_ready_i,
  input wire logic [2:0]  rsp_status_i,
  input wire logic [11:0] rsp_index_i,
  input wire logic [63:0] rsp_data_i
);
  import chrs_pkg::*;

  // a failed command reports neither a record nor data
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != ST_OK |-> rsp_index_i == '0 && rsp_data_i == '0)
    else $error("failed result carries record or data");

  // one command at a time: the input closes after each beat
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("command taken while busy");

  // a new result is never raised by the edge that takes a command
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i && !(rsp_valid_i && !rsp_ready_i) |=> !$rose(rsp_valid_i))
    else $error("result without work");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_index_i) && $stable(rsp_data_i))
    else $error("stalled result changed");
endmodule

bind chained_hash_record_store_core chrs_checker u_chrs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cmd_valid_i  (cmd_i.valid),
  .cmd_ready_i  (cmd_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_index_i  (rsp_o.record_index),
  .rsp_data_i   (rsp_o.read_data)
);
`default_nettype wire

// File: verif/chrs_scoreboard.sv
// chrs_scoreboard: watches the command and result channels of the hash record
// store, predicts each result and compares it. depends on chrs_pkg and chrs_if.
module chrs_scoreboard (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  chrs_cmd_if       cmd_i,
  chrs_rsp_if       rsp_i,
  output int        fail_cnt_o,
  output int        pending_o
);
  import chrs_pkg::*;

  localparam int unsigned NBUCKET = 256;
  localparam int unsigned NWORD   = 4096;
  localparam int unsigned NVAL    = 16;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] rec_idx;
    logic [63:0] rdata;
  } outcome_t;

  logic [63:0] words [NWORD];
  int unsigned free_ptr;
  outcome_t    outcome_q [$];

  assign pending_o = outcome_q.size();

  function automatic bit link_good(logic [63:0] link, int unsigned prev);
    return link > 64'(prev) && link + 64'(HDR) <= 64'(NWORD);
  endfunction

  // walk the chain of a key, returns status and record address
  function automatic status_e chain_find(logic [63:0] key, output int unsigned rec);
    int unsigned prev;
    logic [63:0] link;
    prev = int'(key % 64'(NBUCKET));
    rec = 0;
    link = words[prev];
    while (link != 0) begin
      if (!link_good(link, prev)) return ST_BROKEN;
      if (words[link[11:0] + 1] == key) begin
        rec = link[11:0];
        return ST_OK;
      end
      prev = link[11:0];
      link = words[prev];
    end
    return ST_NOTFOUND;
  endfunction

  function automatic status_e record_add(logic [63:0] key, int unsigned cnt,
                                         output int unsigned rec);
    int unsigned prev;
    int unsigned reuse;
    int unsigned r;
    bit have_reuse;
    logic [63:0] link;
    rec = 0;
    have_reuse = 0;
    reuse = 0;
    if (cnt > NVAL) return ST_SLOT;
    if (key == TOMB_KEY) return ST_DUP;
    prev = int'(key % 64'(NBUCKET));
    link = words[prev];
    while (link != 0) begin
      if (!link_good(link, prev)) return ST_BROKEN;
      r = link[11:0];
      if (!have_reuse && words[r + 1] == TOMB_KEY && words[r + 2] == 64'(cnt)) begin
        have_reuse = 1;
        reuse = r;
      end else if (words[r + 1] == key) begin
        return ST_DUP;
      end
      prev = r;
      link = words[r];
    end
    if (have_reuse) begin
      if (reuse + HDR + cnt > NWORD) return ST_BROKEN;
      for (int i = 0; i < cnt; i++) words[reuse + HDR + i] = '0;
      words[reuse + 1] = key;
      rec = reuse;
      return ST_OK;
    end
    if (free_ptr + HDR + cnt > NWORD) return ST_FULL;
    r = free_ptr;
    words[prev] = 64'(r);
    words[r] = '0;
    words[r + 1] = key;
    words[r + 2] = 64'(cnt);
    for (int i = 0; i < cnt; i++) words[r + HDR + i] = '0;
    free_ptr = r + HDR + cnt;
    rec = r;
    return ST_OK;
  endfunction

  function automatic outcome_t predict_outcome(logic [2:0] cmd, logic [63:0] key,
                                               logic [4:0] cnt, logic [3:0] slot,
                                               logic [63:0] wdata);
    outcome_t o;
    status_e st;
    int unsigned rec;
    int unsigned addr;
    o = '0;
    rec = 0;
    if (cmd == CMD_ADD) begin
      st = record_add(key, cnt, rec);
    end else if (cmd inside {CMD_LOOKUP, CMD_READ, CMD_WRITE, CMD_REMOVE}) begin
      if (key == TOMB_KEY) st = ST_NOTFOUND;
      else st = chain_find(key, rec);
      if (st == ST_OK && (cmd == CMD_READ || cmd == CMD_WRITE)) begin
        addr = rec + HDR + slot;
        if (64'(slot) >= words[rec + 2] || addr >= NWORD) st = ST_SLOT;
        else if (cmd == CMD_READ) o.rdata = words[addr];
        else words[addr] = wdata;
      end else if (st == ST_OK && cmd == CMD_REMOVE) begin
        words[rec + 1] = TOMB_KEY;
      end
    end else begin
      st = ST_NOTFOUND;
    end
    o.status = st;
    if (st == ST_OK) o.rec_idx = rec[11:0];
    else o.rdata = '0;
    return o;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", field, got, want, $realtime);
    fail_cnt_o++;
  endtask

  initial begin
    fail_cnt_o = 0;
    free_ptr = NBUCKET;
    for (int i = 0; i < NWORD; i++) words[i] = '0;
  end

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni) begin
      // compare first: a result can never belong to a command taken at this edge
      if (rsp_i.valid && rsp_i.ready) begin
        if (outcome_q.size() == 0) begin
          report("unexpected result beat", 64'(rsp_i.status), '0);
        end else begin
          want = outcome_q.pop_front();
          if (rsp_i.status !== want.status)
            report("status", 64'(rsp_i.status), 64'(want.status));
          if (rsp_i.record_index !== want.rec_idx)
            report("record_index", 64'(rsp_i.record_index), 64'(want.rec_idx));
          if (rsp_i.read_data !== want.rdata)
            report("read_data", rsp_i.read_data, want.rdata);
        end
      end
      if (cmd_i.valid && cmd_i.ready)
        outcome_q.push_back(predict_outcome(cmd_i.command, cmd_i.key, cmd_i.value_count,
                                            cmd_i.value_slot, cmd_i.write_data));
    end
  end

endmodule

// File: verif/chained_hash_record_store_core_tb.sv
// chained_hash_record_store_core_tb: drives commands into the hash record store
// with random gaps and stalls and gives the verdict. depends on chrs_pkg,
// chrs_if, the core and chrs_scoreboard.
module chained_hash_record_store_core_tb;
  import chrs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned POOL_N = 48;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt;
  int   pending;
  int unsigned cycle_cnt = 0;
  bit   idle_on = 1'b1;
  bit   hold_rsp = 1'b0;
  logic [63:0] key_pool [POOL_N];

  chrs_cmd_if cmd_if ();
  chrs_rsp_if rsp_if ();

  chained_hash_record_store_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if.sink),
    .rsp_o  (rsp_if.source)
  );

  chrs_scoreboard u_scoreboard (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_if),
    .rsp_i      (rsp_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    int unsigned n;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        for (int i = 0; i < 400; i++) @(posedge clk_i);
        hold_rsp = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 8);
        rsp_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        n = $urandom_range(1, 12);
        rsp_if.ready <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // one command beat; the caller is at a rising edge
  task automatic send_cmd(logic [2:0] cmd, logic [63:0] key, logic [4:0] cnt,
                          logic [3:0] slot, logic [63:0] wdata);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.command     <= cmd;
    cmd_if.key         <= key;
    cmd_if.value_count <= cnt;
    cmd_if.value_slot  <= slot;
    cmd_if.write_data  <= wdata;
    do @(posedge clk_i); while (!cmd_if.ready);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pool_key();
    logic [63:0] k;
    k = key_pool[$urandom_range(0, POOL_N - 1)];
    return k;
  endfunction

  task automatic random_cmd();
    logic [2:0] cmd;
    logic [63:0] key;
    logic [4:0] cnt;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) cmd = CMD_ADD;
    else if (pick < 50) cmd = CMD_LOOKUP;
    else if (pick < 68) cmd = CMD_READ;
    else if (pick < 86) cmd = CMD_WRITE;
    else if (pick < 96) cmd = CMD_REMOVE;
    else cmd = 3'($urandom_range(5, 7));
    pick = $urandom_range(0, 99);
    if (pick < 85) key = pool_key();
    else if (pick < 88) key = TOMB_KEY;
    else key = rand_word();
    // keep counts small, so chains stay short and tombstones get reused
    pick = $urandom_range(0, 99);
    if (pick < 70) cnt = 5'($urandom_range(0, 4));
    else if (pick < 95) cnt = 5'($urandom_range(0, 16));
    else cnt = 5'($urandom_range(17, 31));
    // now and then a fresh key takes a place in the pool
    if (cmd == CMD_ADD && $urandom_range(0, 9) == 0) begin
      key = rand_word();
      key_pool[$urandom_range(0, POOL_N - 1)] = key;
    end
    send_cmd(cmd, key, cnt, 4'($urandom), rand_word());
  endtask

  initial begin
    logic [63:0] k;
    cmd_if.valid = 1'b0;
    cmd_if.command = CMD_LOOKUP;
    cmd_if.key = '0;
    cmd_if.value_count = '0;
    cmd_if.value_slot = '0;
    cmd_if.write_data = '0;
    // pool keys crowd into a few buckets so chains get several records
    for (int i = 0; i < POOL_N; i++) begin
      k = rand_word();
      key_pool[i] = {k[63:8], 8'($urandom_range(0, 5) * 37)};
    end
    key_pool[0] = 64'h8000_0000_0000_0000;
    key_pool[1] = 64'h7FFF_FFFF_FFFF_FFFE;
    key_pool[2] = '0;
    key_pool[3] = '1;
    key_pool[4] = 64'h0000_0000_0000_0100;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    send_cmd(CMD_LOOKUP, key_pool[2], 0, 0, 0);
    send_cmd(CMD_ADD, key_pool[2], 16, 0, 0);
    send_cmd(CMD_ADD, key_pool[4], 1, 0, 0);
    send_cmd(CMD_ADD, key_pool[2], 1, 0, 0);
    send_cmd(CMD_ADD, key_pool[0], 0, 0, 0);
    send_cmd(CMD_ADD, key_pool[1], 2, 0, 0);
    send_cmd(CMD_ADD, key_pool[3], 17, 0, 0);
    send_cmd(CMD_ADD, key_pool[3], 31, 0, 0);
    send_cmd(CMD_ADD, TOMB_KEY, 1, 0, 0);
    send_cmd(CMD_WRITE, key_pool[2], 0, 15, '1);
    send_cmd(CMD_WRITE, key_pool[2], 0, 0, 64'h8000_0000_0000_0001);
    send_cmd(CMD_READ, key_pool[2], 0, 15, 0);
    send_cmd(CMD_READ, key_pool[2], 0, 0, 0);
    send_cmd(CMD_READ, key_pool[0], 0, 0, 0);
    send_cmd(CMD_WRITE, key_pool[4], 0, 1, 64'h5555_5555_5555_5555);
    send_cmd(CMD_LOOKUP, key_pool[1], 0, 0, 0);
    send_cmd(CMD_LOOKUP, TOMB_KEY, 0, 0, 0);
    send_cmd(CMD_REMOVE, key_pool[2], 0, 0, 0);
    send_cmd(CMD_LOOKUP, key_pool[2], 0, 0, 0);
    send_cmd(CMD_REMOVE, TOMB_KEY, 0, 0, 0);
    send_cmd(CMD_ADD, key_pool[4] + 64'h100, 16, 0, 0);
    send_cmd(CMD_READ, key_pool[4] + 64'h100, 0, 3, 0);
    send_cmd(3'd5, key_pool[0], 0, 0, 0);
    send_cmd(3'd7, key_pool[0], 0, 0, 0);

    // random part, with the long result hold-off in the middle of it
    for (int i = 0; i < 100; i++) begin
      if (i == 60) hold_rsp = 1'b1;
      random_cmd();
    end

    // sender pause until every result is back
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    // big records with fresh keys until the memory runs out
    for (int i = 0; i < 200; i++) begin
      k = rand_word();
      if (i % 4 == 0) key_pool[$urandom_range(5, POOL_N - 1)] = k;
      send_cmd(CMD_ADD, k, 16, 0, 0);
    end

    for (int i = 0; i < 80; i++) begin
      if (i == 50) idle_on = 1'b0;
      random_cmd();
    end
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// File: files.f
hdl/chrs_pkg.sv
hdl/chrs_if.sv
hdl/chrs_ram.sv
hdl/chrs_bucket.sv
hdl/chained_hash_record_store_core.sv
hdl/chrs_checker.sv
verif/chrs_scoreboard.sv
verif/chained_hash_record_store_core_tb.sv
